@@ hdl/aes_ctr_pkg.sv @@
// package: types, s-box and round helpers for the aes-128 counter mode block
package aes_ctr_pkg;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned BLOCK_BITS = 128;
  localparam int unsigned COUNT_BITS = 5;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_NONCE    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        first_block;
    logic [63:0] init_vector;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_count;
  } out_req_t;

  // what travels alongside the state through the round chain
  typedef struct packed {
    logic [127:0] data;
    logic [15:0]  mask;
    logic [4:0]   count;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit word, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input logic [127:0] w, input int unsigned i);
    return w[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic [127:0] rk,
                                            input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[c*4+i] = sbox(byte_of(s, ((c + i) % 4) * 4 + i));
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r ^ rk;
  endfunction

endpackage

@@ hdl/aes_ctr_cell.sv @@
// one round cell: key expansion step, cipher round, side data carried along
module aes_ctr_cell #(
  parameter logic [7:0] RCON = 8'h01,
  parameter bit LAST = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_in,
  input  logic [127:0]         state_in,
  input  logic [127:0]         key_in,
  input  aes_ctr_pkg::side_t   side_in,
  output logic                 vld_out,
  output logic [127:0]         state_out,
  output logic [127:0]         key_out,
  output aes_ctr_pkg::side_t   side_out
);
  import aes_ctr_pkg::*;

  logic [127:0] rk;
  logic vld_r;
  logic [127:0] state_r, key_r;
  side_t side_r;

  assign rk = key_step(key_in, RCON);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
    if (adv) begin
      state_r <= round_fn(state_in, rk, LAST);
      key_r   <= rk;
      side_r  <= side_in;
    end
  end

  assign vld_out = vld_r;
  assign state_out = state_r;
  assign key_out = key_r;
  assign side_out = side_r;
endmodule

@@ hdl/aes128_counter_mode_crypt.sv @@
// top level: aes-128 counter mode, ten round cells in a chain
// usage:
//   cfg_we/cfg_idx/cfg_data write key_high (0), key_low (1) and nonce (2) while idle.
//   the input channel takes one request per cycle while in_stall is low: a 16-byte
//   block, byte count, first_block flag and iv. the counter block is formed at
//   accept time and enters a chain of ten round cells, one aes round per cell per
//   cycle while the chain advances. a request passes through the whitening
//   register loaded at the accept edge, ten round cells and the output register.
//   throughput: one block per cycle unless the chain holds, set by the
//   one-round-per-cell chain. the whole chain holds while out_stall is high and
//   the output register holds a request; that register then keeps its request,
//   and in_stall is high exactly then, even if the chain behind it is empty.
//   reset clears the key, nonce, iv and block counter and empties the chain.
module aes128_counter_mode_crypt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [aes_ctr_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [aes_ctr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  aes_ctr_pkg::in_req_t            in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output aes_ctr_pkg::out_req_t           out_data
);
  import aes_ctr_pkg::*;

  localparam logic [7:0] RCON [NUM_ROUNDS] =
    '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [63:0] key_high_r, key_low_r, iv_r, iv_nxt;
  logic [31:0] nonce_r;
  logic [15:0] ctr_r, ctr_nxt;
  logic in_acc, adv;

  logic s0_vld_r;
  logic [127:0] s0_state_r, s0_key_r;
  side_t s0_side_r, s_side_in;
  logic [4:0] cnt_sat;

  logic vld_c [NUM_ROUNDS+1];
  logic [127:0] st_c [NUM_ROUNDS+1];
  logic [127:0] ky_c [NUM_ROUNDS+1];
  side_t sd_c [NUM_ROUNDS+1];

  logic out_valid_r;
  out_req_t out_r;
  logic [127:0] res;

  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign in_acc = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      nonce_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_NONCE:    nonce_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign iv_nxt  = in_data.first_block ? in_data.init_vector : iv_r;
  assign ctr_nxt = in_data.first_block ? 16'd1 : ctr_r + 16'd1;
  assign cnt_sat = (in_data.byte_count > 5'd16) ? 5'd16 : in_data.byte_count;

  always_comb begin
    s_side_in.data  = {in_data.block_high, in_data.block_low};
    s_side_in.count = in_data.byte_count;
    for (int i = 0; i < 16; i++) s_side_in.mask[15-i] = (5'(i) < cnt_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= '0;
      ctr_r <= '0;
      s0_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        iv_r <= iv_nxt;
        ctr_r <= ctr_nxt;
      end
      if (adv) s0_vld_r <= in_acc;
    end
    if (adv) begin
      s0_state_r <= {nonce_r, iv_nxt, 16'd0, ctr_nxt} ^ {key_high_r, key_low_r};
      s0_key_r   <= {key_high_r, key_low_r};
      s0_side_r  <= s_side_in;
    end
  end

  assign vld_c[0] = s0_vld_r;
  assign st_c[0]  = s0_state_r;
  assign ky_c[0]  = s0_key_r;
  assign sd_c[0]  = s0_side_r;

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    aes_ctr_cell #(.RCON(RCON[g]), .LAST(g == NUM_ROUNDS - 1)) u_cell (
      .clk, .rst_n, .adv,
      .vld_in(vld_c[g]), .state_in(st_c[g]), .key_in(ky_c[g]), .side_in(sd_c[g]),
      .vld_out(vld_c[g+1]), .state_out(st_c[g+1]), .key_out(ky_c[g+1]),
      .side_out(sd_c[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 16; i++)
      res[127-8*i -: 8] = sd_c[NUM_ROUNDS].mask[15-i] ?
        (byte_of(st_c[NUM_ROUNDS], i) ^ byte_of(sd_c[NUM_ROUNDS].data, i)) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_c[NUM_ROUNDS];
    end
    if (adv) begin
      out_r.result_high  <= res[127:64];
      out_r.result_low   <= res[63:0];
      out_r.result_count <= sd_c[NUM_ROUNDS].count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("output lost");
  a_ctr_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.first_block |=> ctr_r == 16'd1) else $error("counter not set");
  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_data.first_block |=> ctr_r == $past(ctr_r) + 16'd1)
    else $error("counter not advanced");
  a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("stall while empty");
endmodule
